// ===== hw/rtl/limit_order_book_matcher_assert.svh =====
// assertion macros for the order book matcher
`ifndef LIMIT_ORDER_BOOK_MATCHER_ASSERT_SVH
`define LIMIT_ORDER_BOOK_MATCHER_ASSERT_SVH
`ifndef SYNTHESIS
`define LOBM_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define LOBM_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define LOBM_ASSERT(label, clk, rstn, prop)
`define LOBM_ASSERT_RST(label, clk, prop)
`endif
`endif

// ===== hw/rtl/lobm_pkg.sv =====
// ----------------------------------------------------------------------------
// lobm_pkg
// types and codes shared by the order book matcher
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package lobm_pkg;
    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_CANCEL = 2'd1,
        OP_MODIFY = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_FAK_NM   = 3'd2,
        ST_UNKNOWN  = 3'd3,
        ST_FULL     = 3'd4,
        ST_ZERO     = 3'd5
    } status_t;

    localparam logic KIND_TRADE  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic [1:0]         op;
        logic [31:0]        order_id;
        logic               side;
        logic               order_kind;
        logic signed [31:0] limit_price;
        logic [31:0]        amount;
    } in_item_t;

    typedef struct packed {
        logic               item_kind;
        logic [31:0]        buy_id;
        logic signed [31:0] buy_price;
        logic [31:0]        sell_id;
        logic signed [31:0] sell_price;
        logic [31:0]        fill_amount;
        logic [2:0]         status;
        logic [5:0]         resting_total;
        logic               last;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND,
        S_DECIDE,
        S_CHKFAK,
        S_SCAN,
        S_FILL,
        S_TRADE,
        S_REST,
        S_STATUS
    } state_t;
endpackage

// ===== hw/rtl/limit_order_book_matcher.sv =====
// ----------------------------------------------------------------------------
// limit_order_book_matcher
// price-time priority book with one slot-scan unit under a sequencer
// ----------------------------------------------------------------------------
//  channel | ports           | carries
//  input   | s_valid/s_ready | one request item (add, cancel, modify, none)
//  result  | m_valid/m_ready | trade items then one status item with last
//
//  one slot is examined per cycle; each scan visits all ORDER_SLOTS slots
//  a request costs one id scan, one match scan per fill and one more if quantity
//  is left over, and a stall on m_ready adds to this
//  s_ready is high only between requests; reset empties the book at once
`timescale 1ns / 1ps
`include "limit_order_book_matcher_assert.svh"
module limit_order_book_matcher #(
    parameter int ORDER_SLOTS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  lobm_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output lobm_pkg::out_item_t  m_data
);
    localparam int IW = $clog2(ORDER_SLOTS);

    // slot registers, read at the scan index and at the best index
    logic [ORDER_SLOTS-1:0] valid_reg, valid_next;
    logic [31:0] id_mem [ORDER_SLOTS];
    logic        side_mem [ORDER_SLOTS];
    logic        kind_mem [ORDER_SLOTS];
    logic [31:0] price_mem [ORDER_SLOTS];
    logic [31:0] rem_mem [ORDER_SLOTS];
    logic [31:0] arr_mem [ORDER_SLOTS];

    lobm_pkg::state_t state_reg, state_next;
    lobm_pkg::in_item_t req_reg, req_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          hit_reg, hit_next;
    logic [IW-1:0] best_reg, best_next;
    logic [IW-1:0] fslot_reg, fslot_next;
    logic          fhit_reg, fhit_next;
    logic [31:0]   rem_reg, rem_next;
    logic [31:0]   arrc_reg, arrc_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic [2:0]    st_reg, st_next;
    logic          kind_reg, kind_next;
    logic          mv_reg, mv_next;
    lobm_pkg::out_item_t md_reg, md_next;
    logic [31:0]   q_reg, q_next;

    // shared compare unit for one slot
    logic          cur_v, cur_opp, cur_cross, cur_better;
    logic [31:0]   cur_px, best_px;
    logic          last_idx;

    assign last_idx = (idx_reg == IW'(ORDER_SLOTS - 1));
    assign cur_px   = price_mem[idx_reg];
    assign best_px  = price_mem[best_reg];
    assign cur_v    = valid_reg[idx_reg];
    assign cur_opp  = cur_v && (side_mem[idx_reg] != req_reg.side);

    always_comb begin
        logic [31:0] bp, bc, bb;
        bp = req_reg.limit_price ^ 32'h8000_0000;
        bc = cur_px ^ 32'h8000_0000;
        bb = best_px ^ 32'h8000_0000;
        cur_cross = req_reg.side ? (bp <= bc) : (bp >= bc);
        if (cur_px != best_px) begin
            cur_better = req_reg.side ? (bc > bb) : (bc < bb);
        end else begin
            cur_better = (arrc_reg - arr_mem[idx_reg]) > (arrc_reg - arr_mem[best_reg]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lobm_pkg::S_IDLE;
            valid_reg <= '0;
            arrc_reg  <= '0;
            cnt_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            arrc_reg  <= arrc_next;
            cnt_reg   <= cnt_next;
            mv_reg    <= mv_next;
        end
        req_reg   <= req_next;
        idx_reg   <= idx_next;
        hit_reg   <= hit_next;
        best_reg  <= best_next;
        fslot_reg <= fslot_next;
        fhit_reg  <= fhit_next;
        rem_reg   <= rem_next;
        st_reg    <= st_next;
        kind_reg  <= kind_next;
        md_reg    <= md_next;
        q_reg     <= q_next;
    end

    // slot payload writes
    always_ff @(posedge aclk) begin
        if (state_reg == lobm_pkg::S_FILL) begin
            rem_mem[best_reg] <= rem_mem[best_reg] - q_next;
        end
        if (state_reg == lobm_pkg::S_REST && rem_reg != '0 && !kind_reg) begin
            id_mem[fslot_reg]    <= req_reg.order_id;
            side_mem[fslot_reg]  <= req_reg.side;
            kind_mem[fslot_reg]  <= kind_reg;
            price_mem[fslot_reg] <= req_reg.limit_price;
            rem_mem[fslot_reg]   <= rem_reg;
            arr_mem[fslot_reg]   <= arrc_reg;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lobm_pkg::S_IDLE:   if (s_valid) state_next = lobm_pkg::S_FIND;
            lobm_pkg::S_FIND:   if (last_idx) state_next = lobm_pkg::S_DECIDE;
            lobm_pkg::S_DECIDE: begin
                if (req_reg.op == lobm_pkg::OP_ADD || req_reg.op == lobm_pkg::OP_MODIFY) begin
                    if (req_reg.op == lobm_pkg::OP_MODIFY && !hit_reg)
                        state_next = lobm_pkg::S_STATUS;
                    else if (req_reg.op == lobm_pkg::OP_ADD && hit_reg)
                        state_next = lobm_pkg::S_STATUS;
                    else if (req_reg.amount == '0)
                        state_next = lobm_pkg::S_STATUS;
                    else
                        state_next = lobm_pkg::S_SCAN;
                end else begin
                    state_next = lobm_pkg::S_STATUS;
                end
            end
            lobm_pkg::S_SCAN: begin
                if (last_idx) begin
                    priority if (!hit_next && rem_reg == req_reg.amount && kind_reg
                                 && st_reg == lobm_pkg::ST_OK)
                        state_next = lobm_pkg::S_STATUS;
                    else if (!fhit_next && rem_reg == req_reg.amount)
                        state_next = lobm_pkg::S_STATUS;
                    else if (hit_next)
                        state_next = lobm_pkg::S_FILL;
                    else
                        state_next = lobm_pkg::S_REST;
                end
            end
            lobm_pkg::S_FILL:   state_next = lobm_pkg::S_TRADE;
            lobm_pkg::S_TRADE: begin
                if (!mv_reg || m_ready)
                    state_next = (rem_reg == '0) ? lobm_pkg::S_REST : lobm_pkg::S_SCAN;
            end
            lobm_pkg::S_REST:   state_next = lobm_pkg::S_STATUS;
            lobm_pkg::S_STATUS: if (!mv_reg || m_ready) state_next = lobm_pkg::S_IDLE;
            default:            state_next = lobm_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        valid_next = valid_reg;
        arrc_next  = arrc_reg;
        cnt_next   = cnt_reg;
        req_next   = req_reg;
        idx_next   = idx_reg;
        hit_next   = hit_reg;
        best_next  = best_reg;
        fslot_next = fslot_reg;
        fhit_next  = fhit_reg;
        rem_next   = rem_reg;
        st_next    = st_reg;
        kind_next  = kind_reg;
        md_next    = md_reg;
        q_next     = q_reg;
        mv_next    = (mv_reg && !m_ready) ? 1'b1 : 1'b0;
        unique case (state_reg)
            lobm_pkg::S_IDLE: begin
                req_next = s_data;
                idx_next = '0;
                hit_next = 1'b0;
                st_next  = lobm_pkg::ST_OK;
                rem_next = s_data.amount;
                kind_next = s_data.order_kind;
            end
            lobm_pkg::S_FIND: begin
                if (!hit_reg && cur_v && id_mem[idx_reg] == req_reg.order_id) begin
                    hit_next  = 1'b1;
                    best_next = idx_reg;
                end
                idx_next = last_idx ? '0 : idx_reg + 1'b1;
            end
            lobm_pkg::S_DECIDE: begin
                fhit_next = 1'b0;
                if (req_reg.op == lobm_pkg::OP_ADD) begin
                    if (hit_reg) st_next = lobm_pkg::ST_DUP;
                    else if (req_reg.amount == '0) st_next = lobm_pkg::ST_ZERO;
                end else if (req_reg.op == lobm_pkg::OP_NONE) begin
                    st_next = lobm_pkg::ST_OK;
                end else if (!hit_reg) begin
                    st_next = lobm_pkg::ST_UNKNOWN;
                end else begin
                    valid_next[best_reg] = 1'b0;
                    cnt_next = cnt_reg - 6'd1;
                    kind_next = kind_mem[best_reg];
                    if (req_reg.op == lobm_pkg::OP_MODIFY && req_reg.amount == '0)
                        st_next = lobm_pkg::ST_ZERO;
                end
                hit_next = 1'b0;
                idx_next = '0;
            end
            lobm_pkg::S_SCAN: begin
                // also tracks lowest free slot
                if (!cur_v && !fhit_reg) begin
                    fhit_next  = 1'b1;
                    fslot_next = idx_reg;
                end
                if (cur_opp && cur_cross && (!hit_reg || cur_better)) begin
                    hit_next  = 1'b1;
                    best_next = idx_reg;
                end
                idx_next = last_idx ? '0 : idx_reg + 1'b1;
                if (last_idx && rem_reg == req_reg.amount) begin
                    if (!hit_next && kind_reg) st_next = lobm_pkg::ST_FAK_NM;
                    else if (!fhit_next) st_next = lobm_pkg::ST_FULL;
                end
            end
            lobm_pkg::S_FILL: begin
                q_next = (rem_reg < rem_mem[best_reg]) ? rem_reg : rem_mem[best_reg];
                rem_next = rem_reg - q_next;
                if (rem_mem[best_reg] == q_next) begin
                    valid_next[best_reg] = 1'b0;
                    cnt_next = cnt_reg - 6'd1;
                end
            end
            lobm_pkg::S_TRADE: begin
                // trade item is built only once the output register is free
                if (!mv_reg || m_ready) begin
                    mv_next  = 1'b1;
                    md_next = '0;
                    md_next.item_kind = lobm_pkg::KIND_TRADE;
                    md_next.fill_amount = q_reg;
                    if (!req_reg.side) begin
                        md_next.buy_id = req_reg.order_id;
                        md_next.buy_price = req_reg.limit_price;
                        md_next.sell_id = id_mem[best_reg];
                        md_next.sell_price = price_mem[best_reg];
                    end else begin
                        md_next.sell_id = req_reg.order_id;
                        md_next.sell_price = req_reg.limit_price;
                        md_next.buy_id = id_mem[best_reg];
                        md_next.buy_price = price_mem[best_reg];
                    end
                    hit_next = 1'b0;
                    idx_next = '0;
                end
            end
            lobm_pkg::S_REST: begin
                if (rem_reg != '0 && !kind_reg) begin
                    valid_next[fslot_reg] = 1'b1;
                    cnt_next = cnt_reg + 6'd1;
                end
                arrc_next = arrc_reg + 32'd1;
            end
            lobm_pkg::S_STATUS: begin
                if (!mv_reg || m_ready) begin
                    mv_next = 1'b1;
                    md_next = '0;
                    md_next.item_kind = lobm_pkg::KIND_STATUS;
                    md_next.status = st_reg;
                    md_next.resting_total = cnt_reg;
                    md_next.last = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign s_ready = (state_reg == lobm_pkg::S_IDLE);
    assign m_valid = mv_reg;
    assign m_data  = md_reg;

    `LOBM_ASSERT(a_busy_no_ready, aclk, aresetn, (state_reg != lobm_pkg::S_IDLE) |-> !s_ready)
    `LOBM_ASSERT(a_count_match, aclk, aresetn, cnt_reg == 6'($countones(valid_reg)))
    `LOBM_ASSERT(a_status_last, aclk, aresetn, m_valid |-> (m_data.last == m_data.item_kind))
    `LOBM_ASSERT(a_trade_nonzero, aclk, aresetn, (m_valid && !m_data.item_kind) |-> (m_data.fill_amount != '0))
    `LOBM_ASSERT_RST(a_reset_empty, aclk, !aresetn |=> (valid_reg == '0 && !m_valid))
endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// order book matcher: directed table, book-full and sweep tests, random mix;
// each result item checked in order against a local price-time priority model
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top;
    localparam int SLOTS = 32;
    localparam int N_RANDOM = 330;
    localparam longint CYCLE_LIMIT = 5000000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    lobm_pkg::in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    lobm_pkg::out_item_t m_data;

    limit_order_book_matcher #(.ORDER_SLOTS(SLOTS)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #5 aclk = ~aclk;

    // book mirror
    logic        bk_valid [SLOTS];
    logic [31:0] bk_id [SLOTS];
    logic        bk_side [SLOTS];
    logic        bk_kind [SLOTS];
    logic [31:0] bk_price [SLOTS];
    logic [31:0] bk_rem [SLOTS];
    logic [31:0] bk_arr [SLOTS];
    logic [31:0] arrivals;
    logic [5:0]  resting;

    lobm_pkg::out_item_t expected_items[$];
    int errors = 0;
    longint cycles = 0;
    bit quiet = 1'b0;

    function automatic int slot_of(logic [31:0] id);
        for (int i = 0; i < SLOTS; i++)
            if (bk_valid[i] && bk_id[i] == id) return i;
        return -1;
    endfunction

    function automatic int best_match(logic side, logic signed [31:0] px);
        int b;
        logic signed [31:0] sp, bp;
        b = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (!bk_valid[i] || bk_side[i] == side) continue;
            sp = bk_price[i];
            if (side == 1'b0 && px < sp) continue;
            if (side == 1'b1 && px > sp) continue;
            if (b < 0) begin
                b = i;
                continue;
            end
            bp = bk_price[b];
            if (sp != bp) begin
                if ((side == 1'b0) ? (sp < bp) : (sp > bp)) b = i;
            end else if (32'(arrivals - bk_arr[i]) > 32'(arrivals - bk_arr[b])) begin
                b = i;
            end
        end
        return b;
    endfunction

    function automatic lobm_pkg::status_t place_order(lobm_pkg::in_item_t it, logic kind);
        int fs, b;
        logic [31:0] left, q;
        lobm_pkg::out_item_t t;
        fs = -1;
        left = it.amount;
        if (slot_of(it.order_id) >= 0) return lobm_pkg::ST_DUP;
        if (it.amount == 0) return lobm_pkg::ST_ZERO;
        if (kind && best_match(it.side, it.limit_price) < 0) return lobm_pkg::ST_FAK_NM;
        for (int i = 0; i < SLOTS; i++)
            if (!bk_valid[i]) begin
                fs = i;
                break;
            end
        if (fs < 0) return lobm_pkg::ST_FULL;
        while (left != 0) begin
            b = best_match(it.side, it.limit_price);
            if (b < 0) break;
            q = (left < bk_rem[b]) ? left : bk_rem[b];
            left -= q;
            bk_rem[b] -= q;
            t = '0;
            t.item_kind = lobm_pkg::KIND_TRADE;
            t.fill_amount = q;
            if (it.side == 1'b0) begin
                t.buy_id = it.order_id; t.buy_price = it.limit_price;
                t.sell_id = bk_id[b]; t.sell_price = bk_price[b];
            end else begin
                t.buy_id = bk_id[b]; t.buy_price = bk_price[b];
                t.sell_id = it.order_id; t.sell_price = it.limit_price;
            end
            expected_items.insert(expected_items.size(), t);
            if (bk_rem[b] == 0) begin
                bk_valid[b] = 1'b0;
                resting--;
            end
        end
        if (left != 0 && kind == 1'b0) begin
            bk_valid[fs] = 1'b1; bk_id[fs] = it.order_id; bk_side[fs] = it.side;
            bk_kind[fs] = kind; bk_price[fs] = it.limit_price; bk_rem[fs] = left;
            bk_arr[fs] = arrivals;
            resting++;
        end
        arrivals++;
        return lobm_pkg::ST_OK;
    endfunction

    function automatic void predict_request(lobm_pkg::in_item_t it);
        lobm_pkg::status_t st;
        int s;
        lobm_pkg::out_item_t f;
        st = lobm_pkg::ST_OK;
        if (it.op == lobm_pkg::OP_ADD) begin
            st = place_order(it, it.order_kind);
        end else if (it.op == lobm_pkg::OP_CANCEL || it.op == lobm_pkg::OP_MODIFY) begin
            s = slot_of(it.order_id);
            if (s < 0) begin
                st = lobm_pkg::ST_UNKNOWN;
            end else begin
                bk_valid[s] = 1'b0;
                resting--;
                if (it.op == lobm_pkg::OP_MODIFY) st = place_order(it, bk_kind[s]);
            end
        end
        f = '0;
        f.item_kind = lobm_pkg::KIND_STATUS;
        f.status = st;
        f.resting_total = resting;
        f.last = 1'b1;
        expected_items.insert(expected_items.size(), f);
    endfunction

    // result checker and receiver stall
    always @(posedge aclk) begin
        lobm_pkg::out_item_t e;
        cycles <= cycles + 1;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_items.size() == 0) begin
                    $display("%0t: unexpected item expected none actual %p", $time, m_data);
                    errors++;
                end else begin
                    e = expected_items[0];
                    expected_items.delete(0);
                    if (m_data !== e) begin
                        $display("%0t: mismatch expected %p actual %p", $time, e, m_data);
                        errors++;
                    end
                end
            end
            m_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 27);
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // valid stays high from one item to the next unless the sender idles
    task automatic send(lobm_pkg::in_item_t it);
        while (!quiet && $urandom_range(99) < 27) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_request(it);
    endtask

    function automatic lobm_pkg::in_item_t req(lobm_pkg::op_t op, logic [31:0] id,
                                               logic side, logic kind,
                                               logic [31:0] px, logic [31:0] amt);
        lobm_pkg::in_item_t it;
        it.op = op; it.order_id = id; it.side = side; it.order_kind = kind;
        it.limit_price = px; it.amount = amt;
        return it;
    endfunction

    function automatic lobm_pkg::in_item_t random_request();
        logic [31:0] id, px, amt;
        int r;
        r = $urandom_range(99);
        id = ($urandom_range(9) == 0) ? $urandom() : 32'($urandom_range(40));
        if ($urandom_range(19) == 0) px = $urandom();
        else px = 32'($signed($urandom_range(20)) - 10);
        case ($urandom_range(9))
            0: amt = 0;
            1: amt = $urandom();
            default: amt = $urandom_range(1, 20);
        endcase
        if (r < 60)
            return req(lobm_pkg::OP_ADD, id, 1'($urandom_range(1)),
                       $urandom_range(3) == 0, px, amt);
        if (r < 78)
            return req(lobm_pkg::OP_CANCEL, id, 1'($urandom_range(1)),
                       1'($urandom_range(1)), px, amt);
        if (r < 97)
            return req(lobm_pkg::OP_MODIFY, id, 1'($urandom_range(1)),
                       1'($urandom_range(1)), px, amt);
        return req(lobm_pkg::OP_NONE, $urandom(), 1'($urandom_range(1)),
                   1'($urandom_range(1)), $urandom(), $urandom());
    endfunction

    typedef struct {
        lobm_pkg::in_item_t rq;
        bit                 typed;
        lobm_pkg::status_t  st;
        logic [5:0]         tot;
    } step_t;

    step_t directed[$];

    initial begin
        lobm_pkg::in_item_t it;
        lobm_pkg::status_t st;
        for (int i = 0; i < SLOTS; i++) bk_valid[i] = 1'b0;
        arrivals = 0;
        resting = 0;
        directed = '{
            '{req(lobm_pkg::OP_CANCEL, 32'd5, 1'b0, 1'b0, 32'd0, 32'd1),
              1'b1, lobm_pkg::ST_UNKNOWN, 6'd0},
            '{req(lobm_pkg::OP_MODIFY, 32'hFFFFFFFF, 1'b1, 1'b0, 32'd0, 32'd1),
              1'b1, lobm_pkg::ST_UNKNOWN, 6'd0},
            '{req(lobm_pkg::OP_ADD, 32'd1, 1'b0, 1'b0, 32'h7FFFFFFF, 32'd0),
              1'b1, lobm_pkg::ST_ZERO, 6'd0},
            '{req(lobm_pkg::OP_ADD, 32'd1, 1'b0, 1'b1, 32'd10, 32'd5),
              1'b1, lobm_pkg::ST_FAK_NM, 6'd0},
            '{req(lobm_pkg::OP_ADD, 32'd1, 1'b0, 1'b0, 32'd10, 32'hFFFFFFFF),
              1'b1, lobm_pkg::ST_OK, 6'd1},
            '{req(lobm_pkg::OP_ADD, 32'd1, 1'b1, 1'b0, 32'd5, 32'd3),
              1'b1, lobm_pkg::ST_DUP, 6'd1},
            '{req(lobm_pkg::OP_ADD, 32'd2, 1'b0, 1'b0, 32'd10, 32'd4),
              1'b0, lobm_pkg::ST_OK, 6'd0},
            '{req(lobm_pkg::OP_ADD, 32'd3, 1'b0, 1'b0, 32'h80000000, 32'd7),
              1'b0, lobm_pkg::ST_OK, 6'd0},
            '{req(lobm_pkg::OP_ADD, 32'd4, 1'b1, 1'b0, 32'd9, 32'd6),
              1'b0, lobm_pkg::ST_OK, 6'd0},
            '{req(lobm_pkg::OP_ADD, 32'd5, 1'b1, 1'b1, 32'h80000000, 32'hFFFFFFFF),
              1'b0, lobm_pkg::ST_OK, 6'd0},
            '{req(lobm_pkg::OP_ADD, 32'd6, 1'b1, 1'b0, 32'h7FFFFFFF, 32'd2),
              1'b0, lobm_pkg::ST_OK, 6'd0},
            '{req(lobm_pkg::OP_ADD, 32'd7, 1'b0, 1'b1, 32'h7FFFFFFF, 32'd1),
              1'b0, lobm_pkg::ST_OK, 6'd0},
            '{req(lobm_pkg::OP_MODIFY, 32'd3, 1'b1, 1'b0, 32'd20, 32'd5),
              1'b0, lobm_pkg::ST_OK, 6'd0},
            '{req(lobm_pkg::OP_MODIFY, 32'd3, 1'b0, 1'b1, 32'd20, 32'd0),
              1'b0, lobm_pkg::ST_OK, 6'd0},
            '{req(lobm_pkg::OP_NONE, 32'hFFFFFFFF, 1'b1, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF),
              1'b0, lobm_pkg::ST_OK, 6'd0},
            '{req(lobm_pkg::OP_CANCEL, 32'd6, 1'b0, 1'b0, 32'd0, 32'd0),
              1'b0, lobm_pkg::ST_OK, 6'd0}
        };
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed[k]) begin
            send(directed[k].rq);
            if (directed[k].typed) begin
                st = lobm_pkg::status_t'(expected_items[$].status);
                if (st != directed[k].st || expected_items[$].resting_total != directed[k].tot) begin
                    $display("%0t: table row %0d expected %s/%0d actual %s/%0d", $time, k,
                             directed[k].st.name(), directed[k].tot, st.name(),
                             expected_items[$].resting_total);
                    errors++;
                end
            end
        end
        // fill the book to capacity then overflow
        for (int i = 0; i < SLOTS + 1; i++) begin
            it = req(lobm_pkg::OP_ADD, 32'(1000 + i), 1'b1, 1'b0, 32'(500 + i), 32'd1);
            send(it);
        end
        if (expected_items[$].status != lobm_pkg::ST_FULL) begin
            $display("%0t: book full expected %0d actual %0d", $time, lobm_pkg::ST_FULL,
                     expected_items[$].status);
            errors++;
        end
        // one big sweep then hold off until drained
        send(req(lobm_pkg::OP_ADD, 32'd2000, 1'b0, 1'b0, 32'h7FFFFFFF, 32'd100));
        s_valid <= 1'b0;
        while (expected_items.size() != 0) @(posedge aclk);
        for (int i = 0; i < N_RANDOM; i++) begin
            quiet = (i >= 120 && i < 180);
            send(random_request());
        end
        s_valid <= 1'b0;
        quiet = 1'b0;
        while (expected_items.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
